[hw/rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/trg_pkg.sv]
// ----------------------------------------------------------------------------
// trg_pkg
// Widths, limits and sequencer states of the triangular RMS gain block.
// ----------------------------------------------------------------------------
`default_nettype none

package trg_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int SIZE_BITS    = 11;
    localparam int CENTER_BITS  = 10;
    localparam int TARGET_BITS  = 23;
    localparam int GAIN_BITS    = 32;
    localparam int IN_BITS      = 48;
    localparam int MAX_WINDOW   = 1024;
    localparam logic [TARGET_BITS-1:0] TARGET_RESET = 23'd4096;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_INV  = 9'b000000010,
        ST_WGT  = 9'b000000100,
        ST_SCL  = 9'b000001000,
        ST_ACC  = 9'b000010000,
        ST_MEAN = 9'b000100000,
        ST_ROOT = 9'b001000000,
        ST_GAIN = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/triangular_rms_gain_top.sv]
// Flow: a sample is accepted in idle, then weighted, scaled and squared on the
// shared multiplier; a window's first sample with a nonzero half width first
// takes the reciprocal on the shift-subtract unit. After the last sample the
// mean, root and gain steps run before the result is offered (no root or gain
// on zero energy, no gain on a zero root); input is held off meanwhile.
// Reset: synchronous, active low; target returns to 4096, window state clears.
// ----------------------------------------------------------------------------
// triangular_rms_gain_top
// Triangular-window RMS gain: accumulates weighted energy over one window and
// emits target / sqrt(mean energy) in unsigned Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module triangular_rms_gain_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration: target RMS level
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [trg_pkg::TARGET_BITS-1:0] i_cfg_data,
    // sample request
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [23:0] sample, [34:24] size, [44:35] center, [47:45] zero
    input  wire logic [trg_pkg::IN_BITS-1:0]     i_s_tdata,
    // result request
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [31:0] gain
    output logic [trg_pkg::GAIN_BITS-1:0]        o_m_tdata,
    // [0] saturated, [1] zero_energy
    output logic [1:0]                           o_m_tuser
);
    import trg_pkg::*;

    t_state                   r_state, n_state;
    logic [TARGET_BITS-1:0]   r_target;
    logic [63:0]              r_energy, n_energy;
    logic [SIZE_BITS-1:0]     r_count, r_idx, r_size;
    logic [CENTER_BITS-1:0]   r_center;
    logic [16:0]              r_inv, r_weight;
    logic [SAMPLE_BITS-1:0]   r_mag, r_scaled;
    logic [63:0]              r_num, r_quo;
    logic [33:0]              r_rem;
    logic [31:0]              r_div;
    logic [6:0]               r_cnt;
    logic [GAIN_BITS-1:0]     r_gain;
    logic                     r_sat, r_zero;

    logic                     s_take, m_take;
    logic [SAMPLE_BITS-1:0]   raw, mag;
    logic [SIZE_BITS-1:0]     size_in, size_c, c_ext, far_side, hw;
    logic [CENTER_BITS-1:0]   center_in, center_c;
    logic [CENTER_BITS-1:0]   peak_dist;
    logic [23:0]              mul_a, mul_b;
    logic [47:0]              prod;
    logic                     is_root;
    logic [35:0]              shin, trial, diff;
    logic                     ge;
    logic [SIZE_BITS-1:0]     idx_next;
    logic [SIZE_BITS-1:0]     count_div;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_take      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = (r_state == ST_OUT);
    assign m_take      = o_m_tvalid && i_m_tready;
    assign o_m_tdata   = r_gain;
    assign o_m_tuser   = {r_zero, r_sat};

    // Sample magnitude and window geometry of the incoming request.
    assign raw       = i_s_tdata[SAMPLE_BITS-1:0];
    assign mag       = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign size_in   = i_s_tdata[34:24];
    assign center_in = i_s_tdata[44:35];

    always_comb begin
        if (size_in == '0) begin
            size_c = SIZE_BITS'(1);
        end else if (size_in > SIZE_BITS'(MAX_WINDOW)) begin
            size_c = SIZE_BITS'(MAX_WINDOW);
        end else begin
            size_c = size_in;
        end
        c_ext = {1'b0, center_in};
        if (c_ext >= size_c) begin
            c_ext = size_c - 1'b1;
        end
        center_c = c_ext[CENTER_BITS-1:0];
        far_side = size_c - 1'b1 - c_ext;
        hw       = (c_ext > far_side) ? c_ext : far_side;
    end

    // Distance of the current index from the peak.
    assign peak_dist = (r_idx[CENTER_BITS-1:0] > r_center)
                     ? (r_idx[CENTER_BITS-1:0] - r_center)
                     : (r_center - r_idx[CENTER_BITS-1:0]);
    assign idx_next  = r_idx + 1'b1;
    assign count_div = (r_count == '0) ? SIZE_BITS'(1) : r_count;

    // Shared multiplier.
    always_comb begin
        unique case (r_state)
            ST_WGT: begin
                mul_a = {14'd0, peak_dist};
                mul_b = {7'd0, r_inv};
            end
            ST_SCL: begin
                mul_a = r_mag;
                mul_b = {7'd0, r_weight};
            end
            default: begin
                mul_a = r_scaled;
                mul_b = r_scaled;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Shared shift-subtract step: one quotient bit or one root bit per cycle.
    assign is_root = (r_state == ST_ROOT);
    assign shin    = is_root ? {r_rem, r_num[63:62]} : {1'b0, r_rem, r_num[63]};
    assign trial   = is_root ? {2'b00, r_quo[31:0], 2'b01} : {4'd0, r_div};
    assign ge      = (shin >= trial);
    assign diff    = shin - trial;

    assign n_energy = r_energy + {16'd0, prod};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_take) begin
                n_state = (r_idx == '0 && hw != '0) ? ST_INV : ST_WGT;
            end
            ST_INV:  if (r_cnt == '0) n_state = ST_WGT;
            ST_WGT:  n_state = ST_SCL;
            ST_SCL:  n_state = ST_ACC;
            ST_ACC: begin
                if (idx_next >= r_size) begin
                    n_state = (n_energy == '0) ? ST_OUT : ST_MEAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MEAN: if (r_cnt == '0) n_state = ST_ROOT;
            ST_ROOT: if (r_cnt == '0) n_state = (r_quo[30:0] == '0 && !ge) ? ST_OUT : ST_GAIN;
            ST_GAIN: if (r_cnt == '0) n_state = ST_OUT;
            ST_OUT:  if (m_take) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_target <= TARGET_RESET;
            r_energy <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_size   <= '0;
            r_center <= '0;
            r_inv    <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_cfg_data;
            end
            // Load the step counter at each phase start, else count down.
            if (r_state == ST_IDLE && s_take && r_idx == '0) begin
                r_cnt <= 7'd16;
            end else if (r_state == ST_ACC) begin
                r_cnt <= 7'd63;
            end else if (r_state == ST_MEAN && r_cnt == '0) begin
                r_cnt <= 7'd31;
            end else if (r_state == ST_ROOT && r_cnt == '0) begin
                r_cnt <= 7'd46;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            unique case (r_state)
                ST_IDLE: if (s_take) begin
                    if (raw != '0) r_count <= r_count + 1'b1;
                    if (r_idx == '0) begin
                        r_size   <= size_c;
                        r_center <= center_c;
                        r_inv    <= '0;
                    end
                end
                ST_INV:  if (r_cnt == '0) r_inv <= {r_quo[15:0], ge};
                ST_ACC: begin
                    r_energy <= n_energy;
                    r_idx    <= idx_next;
                end
                ST_OUT:  if (m_take) begin
                    r_energy <= '0;
                    r_count  <= '0;
                    r_idx    <= '0;
                    r_size   <= '0;
                    r_center <= '0;
                    r_inv    <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (s_take) begin
                r_mag <= mag;
                r_div <= {22'd0, hw[CENTER_BITS-1:0]};
                r_num <= {1'b1, 63'd0};
                r_rem <= '0;
                r_quo <= '0;
            end
            ST_INV: begin
                r_rem <= ge ? diff[33:0] : shin[33:0];
                r_num <= {r_num[62:0], 1'b0};
                r_quo <= {r_quo[62:0], ge};
            end
            ST_WGT:  r_weight <= (prod[47:16] != '0) ? 17'd0 : (17'h10000 - prod[16:0]);
            ST_SCL:  r_scaled <= prod[39:16];
            ST_ACC: begin
                r_div  <= {21'd0, count_div};
                r_num  <= n_energy;
                r_rem  <= '0;
                r_quo  <= '0;
                r_gain <= '1;
                r_sat  <= 1'b0;
                r_zero <= (n_energy == '0);
            end
            ST_MEAN: begin
                if (r_cnt == '0) begin
                    r_num <= {r_quo[46:0], ge, 16'd0};
                    r_rem <= '0;
                    r_quo <= '0;
                end else begin
                    r_rem <= ge ? diff[33:0] : shin[33:0];
                    r_num <= {r_num[62:0], 1'b0};
                    r_quo <= {r_quo[62:0], ge};
                end
            end
            ST_ROOT: begin
                if (r_cnt == '0) begin
                    r_div <= {r_quo[30:0], ge};
                    r_num <= {r_target, 41'd0};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_sat <= (r_quo[30:0] == '0 && !ge);
                end else begin
                    r_rem <= ge ? diff[33:0] : shin[33:0];
                    r_num <= {r_num[61:0], 2'b00};
                    r_quo <= {r_quo[62:0], ge};
                end
            end
            ST_GAIN: begin
                r_rem <= ge ? diff[33:0] : shin[33:0];
                r_num <= {r_num[62:0], 1'b0};
                r_quo <= {r_quo[62:0], ge};
                if (r_cnt == '0) begin
                    if (r_quo[45:31] != '0) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_gain <= {r_quo[30:0], ge};
                    end
                end
            end
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state), "state not one-hot")
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, o_m_tvalid, !o_s_tready, "input open during output")
    `ASSERT_IMPL(a_zero_gain, i_clk, i_rst_n, o_m_tvalid && r_zero,
                 r_gain == '1 && !r_sat, "zero energy result malformed")
    `ASSERT_NEXT(a_clear, i_clk, i_rst_n, m_take, r_idx == '0 && r_energy == '0,
                 "window not cleared after result")

endmodule

`default_nettype wire
